// File: src/tdavg_pkg.sv
// Package for the temporal depth averaging block with variance rejection.
// Holds status codes, back-end states, register map and reset values.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tdavg_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_VAR  = 2'd2,
		ST_OVER = 2'd3
	} status_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SUB,
		B_CMP,
		B_DIV,
		B_DONE
	} back_state_t;

	// Configuration registers as seen by the datapath
	typedef struct packed {
		logic [15:0] min_depth;
		logic [15:0] max_depth;
		logic [15:0] threshold;
	} cfg_t;

	// Register map: index is paddr[3:2]
	localparam int          ADDR_W  = 4;
	localparam logic [1:0]  REG_MIN = 2'd0;
	localparam logic [1:0]  REG_MAX = 2'd1;
	localparam logic [1:0]  REG_THR = 2'd2;

	localparam logic [15:0] MIN_RST = 16'd0;
	localparam logic [15:0] MAX_RST = 16'd40000;
	localparam logic [15:0] THR_RST = 16'd20;

	// Entries of the queue between front and back
	localparam int          QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// File: src/tdavg_front.sv
// Front end: classifies depth samples and accumulates count, sum and sum of squares.
// On the marked sample, pushes a per-pixel summary into the queue.
// Depends on tdavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdavg_front #(
	parameter int MAX_FRAMES = 16,
	parameter int DEPTH_BITS = 16,
	parameter int REC_W      = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tdavg_pkg::cfg_t   cfg,
	input  wire logic              accept,
	input  wire logic [15:0]       depth_sample,
	input  wire logic              last_of_pixel,
	output logic                   rec_push,
	output logic [REC_W-1:0]       rec_data
);
	import tdavg_pkg::*;

	localparam int DW = (DEPTH_BITS < 16) ? DEPTH_BITS : 16;
	localparam int CW = $clog2(MAX_FRAMES + 2);
	localparam int SW = DW + $clog2(MAX_FRAMES + 1);
	localparam int QW = 2 * DW + $clog2(MAX_FRAMES + 1);

	logic [CW-1:0]   valid_cnt_q, samp_cnt_q;
	logic [SW-1:0]   sum_q;
	logic [QW-1:0]   sq_q;

	logic [DW-1:0]   d;
	logic [15:0]     d16;
	logic [2*DW-1:0] d_sq;
	logic            room, take;
	logic [CW-1:0]   valid_nxt, samp_nxt;
	logic [SW-1:0]   sum_nxt;
	logic [QW-1:0]   sq_nxt;

	assign d    = depth_sample[DW-1:0];
	assign d16  = 16'(d);
	assign d_sq = (2*DW)'(d) * (2*DW)'(d);
	assign room = samp_cnt_q < CW'(MAX_FRAMES);
	assign take = room && (d16 > cfg.min_depth) && (d16 < cfg.max_depth);

	always_comb begin
		valid_nxt = valid_cnt_q;
		sum_nxt   = sum_q;
		sq_nxt    = sq_q;
		if (take) begin
			valid_nxt = valid_cnt_q + CW'(1);
			sum_nxt   = sum_q + SW'(d);
			sq_nxt    = sq_q + QW'(d_sq);
		end
		samp_nxt = room ? samp_cnt_q + CW'(1) : CW'(MAX_FRAMES + 1);
	end

	// Summary: over flag, valid count, sum, sum of squares
	assign rec_push = accept && last_of_pixel;
	assign rec_data = {(samp_nxt > CW'(MAX_FRAMES)), valid_nxt, sum_nxt, sq_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_cnt_q <= '0;
			samp_cnt_q  <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
		end else if (accept) begin
			if (last_of_pixel) begin
				valid_cnt_q <= '0;
				samp_cnt_q  <= '0;
				sum_q       <= '0;
				sq_q        <= '0;
			end else begin
				valid_cnt_q <= valid_nxt;
				samp_cnt_q  <= samp_nxt;
				sum_q       <= sum_nxt;
				sq_q        <= sq_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/tdavg_fifo.sv
// Short queue of pixel summaries between the front and back ends.
// Depends on tdavg_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module tdavg_fifo #(
	parameter int WIDTH = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	import tdavg_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == NW'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: src/tdavg_back.sv
// Back end: variance test and mean division for one pixel summary at a time.
// Holds the result register that feeds the output queue ports.
// Depends on tdavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdavg_back #(
	parameter int MAX_FRAMES = 16,
	parameter int DEPTH_BITS = 16,
	parameter int REC_W      = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tdavg_pkg::cfg_t   cfg,
	input  wire logic              rec_empty,
	input  wire logic [REC_W-1:0]  rec_data,
	output logic                   rec_pop,
	input  wire logic              pop,
	output logic                   empty,
	output logic [15:0]            mean_depth,
	output logic [1:0]             status
);
	import tdavg_pkg::*;

	localparam int DW    = (DEPTH_BITS < 16) ? DEPTH_BITS : 16;
	localparam int CW    = $clog2(MAX_FRAMES + 2);
	localparam int SW    = DW + $clog2(MAX_FRAMES + 1);
	localparam int QW    = 2 * DW + $clog2(MAX_FRAMES + 1);
	localparam int VW    = CW + QW;
	localparam int LIM_W = 32 + 2 * CW;
	localparam int CMP_W = (VW > LIM_W) ? VW : LIM_W;
	localparam int KW    = $clog2(SW + 1);

	back_state_t     state_q, state_nxt;

	logic            over_q;
	logic [CW-1:0]   n_q;
	logic [SW-1:0]   sum_q;
	logic [QW-1:0]   sq_q;
	logic [VW-1:0]   p_nsq_q, spread_q;
	logic [2*SW-1:0] p_ss_q;
	logic [31:0]     t2_q;
	logic [2*CW-1:0] nn1_q;
	logic [LIM_W-1:0] lim_q;
	logic [SW-1:0]   quo_q;
	logic [CW:0]     rem_q;
	logic [KW-1:0]   div_cnt_q;
	status_t         stat_q;

	logic            out_valid_q;
	logic [15:0]     mean_q;
	status_t         status_q;

	logic            pass;
	logic [CW:0]     trial;
	logic            ge;
	logic            res_load;

	assign pass  = (n_q == CW'(1)) ? (cfg.threshold != '0)
	                                : (CMP_W'(spread_q) < CMP_W'(lim_q));
	assign trial = {rem_q[CW-1:0], quo_q[SW-1]};
	assign ge    = trial >= (CW+1)'(n_q);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			B_IDLE: if (!rec_empty) state_nxt = B_MUL;
			B_MUL:  state_nxt = B_SUB;
			B_SUB:  state_nxt = B_CMP;
			B_CMP: begin
				if (!over_q && n_q != '0 && pass) state_nxt = B_DIV;
				else                              state_nxt = B_DONE;
			end
			B_DIV:  if (div_cnt_q == KW'(1)) state_nxt = B_DONE;
			B_DONE: if (res_load) state_nxt = B_IDLE;
			default: state_nxt = B_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		rec_pop  = 1'b0;
		res_load = 1'b0;
		case (state_q)
			B_IDLE:  rec_pop  = !rec_empty;
			B_DONE:  res_load = !out_valid_q || pop;
			default: begin
				rec_pop  = 1'b0;
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				{over_q, n_q, sum_q, sq_q} <= rec_data;
			end
			B_MUL: begin
				p_nsq_q <= VW'(n_q) * VW'(sq_q);
				p_ss_q  <= (2*SW)'(sum_q) * (2*SW)'(sum_q);
				t2_q    <= 32'(cfg.threshold) * 32'(cfg.threshold);
				nn1_q   <= (2*CW)'(n_q) * (2*CW)'(n_q - CW'(1));
			end
			B_SUB: begin
				spread_q <= p_nsq_q - VW'(p_ss_q);
				lim_q    <= LIM_W'(t2_q) * LIM_W'(nn1_q);
			end
			B_CMP: begin
				rem_q     <= '0;
				div_cnt_q <= KW'(SW);
				if (over_q) begin
					stat_q <= ST_OVER;
					quo_q  <= '0;
				end else if (n_q == '0) begin
					stat_q <= ST_NONE;
					quo_q  <= '0;
				end else if (pass) begin
					stat_q <= ST_OK;
					quo_q  <= sum_q;
				end else begin
					stat_q <= ST_VAR;
					quo_q  <= '0;
				end
			end
			B_DIV: begin
				// One restoring step: shift in the next dividend bit, subtract if it fits
				rem_q     <= ge ? trial - (CW+1)'(n_q) : trial;
				quo_q     <= {quo_q[SW-2:0], ge};
				div_cnt_q <= div_cnt_q - KW'(1);
			end
			default: begin
			end
		endcase
		if (res_load) begin
			mean_q   <= 16'(quo_q);
			status_q <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty      = !out_valid_q;
	assign mean_depth = mean_q;
	assign status     = status_q;

endmodule

`default_nettype wire

// File: src/temporal_depth_average_variance_gate.sv
// Temporal depth averaging with variance rejection, one pixel per run of samples.
// Throughput: one depth sample per cycle while the summary queue has room. The back end
// runs its multiply, subtract and compare steps on every pixel and its bit-serial divider
// only on an accepted one; a full queue stalls input.
// A summary passes the queue, then back-end states MUL, SUB, CMP, DIV (accepted only) and DONE.
// Reset (arst_n low, async): accumulators and queue cleared, result empty; min 0, max 40000, threshold 20.
`timescale 1ns / 1ps
`default_nettype none

module temporal_depth_average_variance_gate #(
	parameter int MAX_FRAMES = 16,
	parameter int DEPTH_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tdavg_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// sample side
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [15:0]                  depth_sample,
	input  wire logic                         last_of_pixel,
	// result side
	input  wire logic                         pop,
	output logic                              empty,
	output logic [15:0]                       mean_depth,
	output logic [1:0]                        status
);
	import tdavg_pkg::*;

	// Summary record layout: over flag, valid count, sum, sum of squares
	localparam int DW    = (DEPTH_BITS < 16) ? DEPTH_BITS : 16;
	localparam int CW    = $clog2(MAX_FRAMES + 2);
	localparam int SW    = DW + $clog2(MAX_FRAMES + 1);
	localparam int QW    = 2 * DW + $clog2(MAX_FRAMES + 1);
	localparam int REC_W = 1 + CW + SW + QW;

	logic [15:0]      min_q, max_q, thr_q;
	cfg_t             cfg;
	logic [1:0]       reg_idx;
	logic             cfg_wr;
	logic             in_acc;
	logic             rec_push, rec_pop, rec_empty, q_full;
	logic [REC_W-1:0] rec_wdata, rec_rdata;

	// Configuration port: zero wait states, word index in paddr[3:2]
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_RST;
			max_q <= MAX_RST;
			thr_q <= THR_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MIN: min_q <= pwdata[15:0];
				REG_MAX: max_q <= pwdata[15:0];
				REG_THR: thr_q <= pwdata[15:0];
				default: begin
					// drop writes to unmapped addresses
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN: prdata = 32'(min_q);
			REG_MAX: prdata = 32'(max_q);
			REG_THR: prdata = 32'(thr_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.min_depth = min_q;
	assign cfg.max_depth = max_q;
	assign cfg.threshold = thr_q;

	// Hold off samples only while the summary queue is full; the front end
	// pushes a summary on the marked sample, so this keeps every transaction.
	assign full   = q_full;
	assign in_acc = push && !q_full;

	tdavg_front #(
		.MAX_FRAMES (MAX_FRAMES),
		.DEPTH_BITS (DEPTH_BITS),
		.REC_W      (REC_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.accept        (in_acc),
		.depth_sample  (depth_sample),
		.last_of_pixel (last_of_pixel),
		.rec_push      (rec_push),
		.rec_data      (rec_wdata)
	);

	// Decouple accumulation from the slow variance test and divide
	tdavg_fifo #(
		.WIDTH (REC_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_wdata),
		.full   (q_full),
		.pop    (rec_pop),
		.rdata  (rec_rdata),
		.empty  (rec_empty)
	);

	// Back end owns the result register, so it can start the next pixel
	// while the previous result waits for a pop transaction.
	tdavg_back #(
		.MAX_FRAMES (MAX_FRAMES),
		.DEPTH_BITS (DEPTH_BITS),
		.REC_W      (REC_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.rec_empty  (rec_empty),
		.rec_data   (rec_rdata),
		.rec_pop    (rec_pop),
		.pop        (pop),
		.empty      (empty),
		.mean_depth (mean_depth),
		.status     (status)
	);

endmodule

`default_nettype wire
